FILE: rtl/crt_pkg.sv
// Shared constants for the congruence combiner: port widths and status codes.
// No dependencies.
package crt_pkg;

    // Fixed widths of the word fields on the ports.
    localparam int IN_W  = 32;
    localparam int OUT_W = 63;
    localparam int ST_W  = 2;

    // Status codes reported with each result word.
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_INCONSIS = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

FILE: rtl/crt_congruence_combiner.sv
// Generalized CRT combiner: folds congruences into a running residue and modulus.
// Depends on crt_pkg for port widths and status codes.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one congruence word: residue, modulus
//   and a last flag. A word is taken when i_valid is high and o_stall is low.
//   o_stall is high while a word is being folded in.
//   Output channel (o_valid / i_stall) carries one result word per set, only
//   after the word marked last: solution, combined modulus and status.
//   Each word is worked by one shared shift-subtract / shift-add unit under a
//   small sequencer. Divisions run over a DIVW-bit numerator (DIVW = max(ACC_WIDTH,
//   2*MODULUS_WIDTH)), multiplications over a MODULUS_WIDTH-bit multiplier.
//   Once a set has failed, later words of it skip the arithmetic and pass
//   straight to the final step of the sequencer.
//   The result sits in an output register, so the next word may be taken
//   while the receiver stalls; the final step of a set waits for that
//   register to free up. Reset clears the accumulator to residue 0, modulus 1,
//   status ok, and drops any pending result.
module crt_congruence_combiner #(
    parameter int MODULUS_WIDTH = 32,
    parameter int ACC_WIDTH     = 63
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [crt_pkg::IN_W-1:0]        i_residue,
    input  logic [crt_pkg::IN_W-1:0]        i_modulus,
    input  logic                            i_last,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [crt_pkg::OUT_W-1:0]       o_solution,
    output logic [crt_pkg::OUT_W-1:0]       o_combined_modulus,
    output logic [crt_pkg::ST_W-1:0]        o_status
);

    localparam int MW   = MODULUS_WIDTH;
    localparam int AW   = ACC_WIDTH;
    localparam int DIVW = (AW > 2 * MW) ? AW : 2 * MW;
    localparam int PW   = ((AW > MW) ? AW : MW) + MW;
    localparam int SW   = MW + 3;
    localparam int CW   = $clog2(DIVW + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BMOD = 4'd1;
    localparam logic [3:0] S_MREM = 4'd2;
    localparam logic [3:0] S_EUC  = 4'd3;
    localparam logic [3:0] S_RREM = 4'd4;
    localparam logic [3:0] S_DDIV = 4'd5;
    localparam logic [3:0] S_MRED = 4'd6;
    localparam logic [3:0] S_OVF  = 4'd7;
    localparam logic [3:0] S_PMOD = 4'd8;
    localparam logic [3:0] S_TMUL = 4'd9;
    localparam logic [3:0] S_TMOD = 4'd10;
    localparam logic [3:0] S_RMUL = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]            r_state;
    logic [CW-1:0]         r_cnt;

    // Accumulated solution.
    logic [AW-1:0]         r_acc_res;
    logic [AW-1:0]         r_acc_mod;
    logic [crt_pkg::ST_W-1:0] r_fail;

    // Current congruence and intermediate values.
    logic [MW-1:0]         r_b;
    logic [MW-1:0]         r_m;
    logic                  r_last;
    logic [MW-1:0]         r_eb;
    logic signed [SW-1:0]  r_sprev;
    logic signed [SW-1:0]  r_scur;
    logic [MW-1:0]         r_d;
    logic [MW-1:0]         r_qd;
    logic [MW-1:0]         r_mred;
    logic [AW-1:0]         r_newm;

    // Shared unit registers.
    logic [DIVW-1:0]       r_num;
    logic [MW-1:0]         r_rem;
    logic [MW-1:0]         r_den;
    logic signed [SW-1:0]  r_qs;
    logic [PW-1:0]         r_mpa;
    logic [MW-1:0]         r_mpb;
    logic [PW-1:0]         r_prod;

    // Output register.
    logic                  r_ovalid;
    logic [crt_pkg::OUT_W-1:0] r_osol;
    logic [crt_pkg::OUT_W-1:0] r_omod;
    logic [crt_pkg::ST_W-1:0]  r_ostat;

    logic                  mul_op;
    logic [MW:0]           div_tmp;
    logic                  div_ge;
    logic [MW:0]           div_sub;
    logic [MW-1:0]         n_rem;
    logic [MW-1:0]         m_in;
    logic [MW:0]           diff_wide;
    logic [MW-1:0]         diff;
    logic [SW-1:0]         p_abs;
    logic [MW-1:0]         pm;
    logic                  accept;
    logic                  out_free;
    logic                  emit;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_solution         = r_osol;
    assign o_combined_modulus = r_omod;
    assign o_status           = r_ostat;

    // A result word is loaded at this edge.
    assign emit = (r_cnt == '0) && (r_state == S_DONE) && r_last && out_free;

    // Multiplication states run the shift-add path, all others shift-subtract.
    assign mul_op = r_state inside {S_OVF, S_TMUL, S_RMUL};

    // One restoring division step.
    always_comb begin
        div_tmp = {r_rem, r_num[DIVW-1]};
        div_ge  = (div_tmp >= {1'b0, r_den});
        div_sub = div_tmp - {1'b0, r_den};
        n_rem   = div_ge ? div_sub[MW-1:0] : div_tmp[MW-1:0];
    end

    // Input modulus with zero treated as one.
    assign m_in = (i_modulus[MW-1:0] == '0) ? MW'(1) : i_modulus[MW-1:0];

    // Difference (b - r) reduced mod m, from r mod m held in the remainder.
    assign diff_wide = (r_b >= r_rem) ? ({1'b0, r_b} - {1'b0, r_rem})
                                      : ({1'b0, r_b} + {1'b0, r_m} - {1'b0, r_rem});
    assign diff = diff_wide[MW-1:0];

    // Magnitude of the Euclid coefficient and its positive residue mod m/d.
    assign p_abs = r_sprev[SW-1] ? SW'(-r_sprev) : SW'(r_sprev);
    assign pm    = (r_sprev[SW-1] && (r_rem != '0)) ? (r_mred - r_rem) : r_rem;

    // Sequencer and shared arithmetic unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_acc_res <= '0;
            r_acc_mod <= AW'(1);
            r_fail    <= crt_pkg::ST_OK;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && !emit) begin
                r_ovalid <= 1'b0;
            end
            if (r_cnt != '0) begin
                // Iterate the shared unit.
                r_cnt <= r_cnt - CW'(1);
                if (mul_op) begin
                    r_prod <= {r_prod[PW-2:0], 1'b0} + (r_mpb[MW-1] ? r_mpa : '0);
                    r_mpb  <= {r_mpb[MW-2:0], 1'b0};
                end else begin
                    r_rem <= n_rem;
                    r_num <= {r_num[DIVW-2:0], div_ge};
                    r_qs  <= (r_qs <<< 1) + (div_ge ? r_scur : '0);
                end
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (accept) begin
                            r_b    <= i_residue[MW-1:0];
                            r_m    <= m_in;
                            r_last <= i_last;
                            if (r_fail != crt_pkg::ST_OK) begin
                                r_state <= S_DONE;
                            end else begin
                                r_num   <= DIVW'(i_residue[MW-1:0]);
                                r_rem   <= '0;
                                r_den   <= m_in;
                                r_qs    <= '0;
                                r_cnt   <= CW'(DIVW);
                                r_state <= S_BMOD;
                            end
                        end
                    end
                    S_BMOD: begin
                        r_b     <= r_rem;
                        r_num   <= DIVW'(r_acc_mod);
                        r_rem   <= '0;
                        r_den   <= r_m;
                        r_qs    <= '0;
                        r_cnt   <= CW'(DIVW);
                        r_state <= S_MREM;
                    end
                    S_MREM: begin
                        // Start extended Euclid on (M mod m, m).
                        r_eb    <= r_m;
                        r_sprev <= SW'(1);
                        r_scur  <= '0;
                        r_num   <= DIVW'(r_rem);
                        r_rem   <= '0;
                        r_den   <= r_m;
                        r_qs    <= '0;
                        r_cnt   <= CW'(DIVW);
                        r_state <= S_EUC;
                    end
                    S_EUC: begin
                        r_eb    <= r_rem;
                        r_sprev <= r_scur;
                        r_scur  <= r_sprev - r_qs;
                        r_qs    <= '0;
                        if (r_rem == '0) begin
                            // gcd found; reduce r mod m next.
                            r_d     <= r_eb;
                            r_num   <= DIVW'(r_acc_res);
                            r_rem   <= '0;
                            r_den   <= r_m;
                            r_cnt   <= CW'(DIVW);
                            r_state <= S_RREM;
                        end else begin
                            r_num   <= DIVW'(r_eb);
                            r_rem   <= '0;
                            r_den   <= r_rem;
                            r_cnt   <= CW'(DIVW);
                        end
                    end
                    S_RREM: begin
                        r_num   <= DIVW'(diff);
                        r_rem   <= '0;
                        r_den   <= r_d;
                        r_qs    <= '0;
                        r_cnt   <= CW'(DIVW);
                        r_state <= S_DDIV;
                    end
                    S_DDIV: begin
                        if (r_rem != '0) begin
                            r_fail  <= crt_pkg::ST_INCONSIS;
                            r_state <= S_DONE;
                        end else begin
                            r_qd    <= r_num[MW-1:0];
                            r_num   <= DIVW'(r_m);
                            r_rem   <= '0;
                            r_den   <= r_d;
                            r_qs    <= '0;
                            r_cnt   <= CW'(DIVW);
                            r_state <= S_MRED;
                        end
                    end
                    S_MRED: begin
                        r_mred  <= r_num[MW-1:0];
                        r_mpa   <= PW'(r_acc_mod);
                        r_mpb   <= r_num[MW-1:0];
                        r_prod  <= '0;
                        r_cnt   <= CW'(MW);
                        r_state <= S_OVF;
                    end
                    S_OVF: begin
                        if (r_prod[PW-1:AW] != '0) begin
                            r_fail  <= crt_pkg::ST_OVERFLOW;
                            r_state <= S_DONE;
                        end else begin
                            r_newm  <= r_prod[AW-1:0];
                            r_num   <= DIVW'(p_abs[MW-1:0]);
                            r_rem   <= '0;
                            r_den   <= r_mred;
                            r_qs    <= '0;
                            r_cnt   <= CW'(DIVW);
                            r_state <= S_PMOD;
                        end
                    end
                    S_PMOD: begin
                        r_mpa   <= PW'(r_qd);
                        r_mpb   <= pm;
                        r_prod  <= '0;
                        r_cnt   <= CW'(MW);
                        r_state <= S_TMUL;
                    end
                    S_TMUL: begin
                        r_num   <= DIVW'(r_prod[2*MW-1:0]);
                        r_rem   <= '0;
                        r_den   <= r_mred;
                        r_qs    <= '0;
                        r_cnt   <= CW'(DIVW);
                        r_state <= S_TMOD;
                    end
                    S_TMOD: begin
                        r_mpa   <= PW'(r_acc_mod);
                        r_mpb   <= r_rem;
                        r_prod  <= '0;
                        r_cnt   <= CW'(MW);
                        r_state <= S_RMUL;
                    end
                    S_RMUL: begin
                        r_acc_res <= r_acc_res + r_prod[AW-1:0];
                        r_acc_mod <= r_newm;
                        r_state   <= S_DONE;
                    end
                    S_DONE: begin
                        if (!r_last) begin
                            r_state <= S_IDLE;
                        end else if (out_free) begin
                            // Emit the result word and restart the accumulator.
                            r_ovalid <= 1'b1;
                            if (r_fail == crt_pkg::ST_OK) begin
                                r_osol <= crt_pkg::OUT_W'(r_acc_res);
                                r_omod <= crt_pkg::OUT_W'(r_acc_mod);
                            end else begin
                                r_osol <= '0;
                                r_omod <= '0;
                            end
                            r_ostat   <= r_fail;
                            r_acc_res <= '0;
                            r_acc_mod <= AW'(1);
                            r_fail    <= crt_pkg::ST_OK;
                            r_state   <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // The combined modulus never becomes zero.
    a_mod_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_mod != '0)
        else $error("combined modulus reached zero");

    // The solution stays below the combined modulus between words.
    a_res_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_fail == crt_pkg::ST_OK) |-> (r_acc_res < r_acc_mod))
        else $error("solution not below combined modulus");

    // A new result word only appears out of the final step of a set.
    a_emit_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_DONE && $past(r_last)))
        else $error("result word raised outside the final step");

    // The shared unit is quiet whenever a new word may be taken.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("shared unit busy while idle");

endmodule

FILE: bench/tb_crt_congruence_combiner.sv
// Self-checking testbench for crt_congruence_combiner: congruence sets are driven in,
// and each result word is compared with an in-bench CRT fold.
// Depends on crt_pkg and the crt_congruence_combiner RTL.
`timescale 1ns / 100ps

module tb_crt_congruence_combiner;

    localparam longint unsigned ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 100000;

    typedef struct packed {
        logic [crt_pkg::OUT_W-1:0] solution;
        logic [crt_pkg::OUT_W-1:0] modulus;
        logic [crt_pkg::ST_W-1:0]  status;
    } t_crt_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [crt_pkg::IN_W-1:0]    i_residue = '0;
    logic [crt_pkg::IN_W-1:0]    i_modulus = '0;
    logic                        i_last = 1'b0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [crt_pkg::OUT_W-1:0]   o_solution;
    logic [crt_pkg::OUT_W-1:0]   o_combined_modulus;
    logic [crt_pkg::ST_W-1:0]    o_status;

    crt_congruence_combiner dut (.*);

    // Clock: 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Running solution of the current set, as the block should hold it.
    longint unsigned             acc_res = 0;
    longint unsigned             acc_mod = 1;
    logic [crt_pkg::ST_W-1:0]    set_fail = crt_pkg::ST_OK;
    t_crt_result                 expected_q[$];

    int  errors = 0;
    int  n_words = 0;
    int  n_results = 0;
    int  n_inconsistent = 0;
    int  n_overflow = 0;
    bit  idle_on = 1'b1;
    int  pressure_req = 0;

    // Fold one congruence into the running solution (generalized CRT).
    function automatic void fold_congruence(input longint unsigned b, input longint unsigned m);
        longint unsigned a, bb, q, rm, d, r_rem, diff, m_red, t;
        longint          s_prev, s_cur, s_next, pm;
        if (m == 0) m = 1;
        b = b % m;
        a = acc_mod % m;
        bb = m;
        s_prev = 1;
        s_cur = 0;
        while (bb != 0) begin
            q = a / bb;
            rm = a - q * bb;
            s_next = s_prev - longint'(q) * s_cur;
            a = bb;
            bb = rm;
            s_prev = s_cur;
            s_cur = s_next;
        end
        d = a;
        r_rem = acc_res % m;
        diff = (b >= r_rem) ? (b - r_rem) : (b + m - r_rem);
        if (diff % d != 0) begin
            set_fail = crt_pkg::ST_INCONSIS;
            return;
        end
        m_red = m / d;
        if (acc_mod > ACC_MAX / m_red) begin
            set_fail = crt_pkg::ST_OVERFLOW;
            return;
        end
        pm = s_prev % longint'(m_red);
        if (pm < 0) pm = pm + longint'(m_red);
        t = ((diff / d) * longint'(pm)) % m_red;
        acc_res = acc_res + acc_mod * t;
        acc_mod = acc_mod * m_red;
    endfunction

    // Predict the effect of one accepted word and queue any result it causes.
    function automatic void predict_word(input logic [crt_pkg::IN_W-1:0] b,
                                         input logic [crt_pkg::IN_W-1:0] m,
                                         input logic last);
        t_crt_result res;
        if (set_fail == crt_pkg::ST_OK) fold_congruence(64'(b), 64'(m));
        if (last) begin
            if (set_fail == crt_pkg::ST_OK) begin
                res.solution = acc_res[crt_pkg::OUT_W-1:0];
                res.modulus = acc_mod[crt_pkg::OUT_W-1:0];
            end else begin
                res.solution = '0;
                res.modulus = '0;
            end
            res.status = set_fail;
            if (set_fail == crt_pkg::ST_INCONSIS) n_inconsistent++;
            if (set_fail == crt_pkg::ST_OVERFLOW) n_overflow++;
            expected_q.push_back(res);
            acc_res = 0;
            acc_mod = 1;
            set_fail = crt_pkg::ST_OK;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_crt_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result word, solution", 64'(o_solution),
                                64'(0));
            end else begin
                exp_r = expected_q.pop_front();
                if (o_solution !== exp_r.solution)
                    report_mismatch("solution", 64'(o_solution), 64'(exp_r.solution));
                if (o_combined_modulus !== exp_r.modulus)
                    report_mismatch("combined_modulus", 64'(o_combined_modulus),
                                    64'(exp_r.modulus));
                if (o_status !== exp_r.status)
                    report_mismatch("status", 64'(o_status), 64'(exp_r.status));
            end
        end
    end

    // Receiver: random stall bursts, plus long holds on request.
    int stall_left = 0;
    int hold_left = 0;
    int pressure_seen = 0;
    always @(posedge i_clk) begin
        if (pressure_seen != pressure_req) begin
            pressure_seen = pressure_req;
            hold_left = 6000;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog on cycles in which no word moves on either channel.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved in %0d cycles", STALL_LIMIT);
                $display("crt_congruence_combiner test failed");
                $finish;
            end
        end
    end

    // Send one congruence word, with an occasional idle burst before it.
    task automatic send_word(input logic [crt_pkg::IN_W-1:0] b,
                             input logic [crt_pkg::IN_W-1:0] m, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_residue <= b;
        i_modulus <= m;
        i_last <= last;
        do @(posedge i_clk); while (o_stall);
        predict_word(b, m, last);
        n_words++;
    endtask

    // Plain consistent sets, trivial and full-width ones.
    task automatic test_basic_sets();
        send_word(32'd0, 32'd1, 1'b1);
        send_word(32'd2, 32'd3, 1'b0);
        send_word(32'd3, 32'd5, 1'b0);
        send_word(32'd2, 32'd7, 1'b1);
        send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
        send_word(32'd5, 32'd12, 1'b0);
        send_word(32'd11, 32'd18, 1'b1);
    endtask

    // Zero modulus and residues not below their modulus.
    task automatic test_special_moduli();
        send_word(32'hFFFF_FFFF, 32'd0, 1'b1);
        send_word(32'd17, 32'd5, 1'b0);
        send_word(32'h1234_5678, 32'd0, 1'b0);
        send_word(32'hFFFF_FFFF, 32'd1000, 1'b1);
        send_word(32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    endtask

    // Inconsistent and overflowing sets, and words after the first failure.
    task automatic test_failures();
        send_word(32'd0, 32'd4, 1'b0);
        send_word(32'd1, 32'd6, 1'b0);
        send_word(32'd0, 32'd7, 1'b1);
        send_word(32'd1, 32'd4294967291, 1'b0);
        send_word(32'd2, 32'd4294967279, 1'b0);
        send_word(32'd3, 32'd4294967231, 1'b0);
        send_word(32'd0, 32'd4, 1'b0);
        send_word(32'd1, 32'd4, 1'b1);
    endtask

    // Receiver holds off for a long stretch while single-word sets keep coming.
    task automatic test_pressure();
        pressure_req++;
        repeat (5) send_word($urandom, $urandom, 1'b1);
    endtask

    // One random set: mostly consistent with a hidden 64-bit solution.
    task automatic random_set();
        int                          len, kind, sel;
        longint unsigned             x, mm, rr;
        logic [crt_pkg::IN_W-1:0]    base_f;
        len = $urandom_range(1, 5);
        kind = $urandom_range(0, 9);
        x = {$urandom, $urandom};
        base_f = $urandom_range(2, 5000);
        for (int k = 0; k < len; k++) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1: mm = 64'($urandom_range(1, 64));
                2, 3: mm = 64'($urandom_range(1, 65535));
                4, 5: mm = 64'(base_f) * 64'($urandom_range(1, 200));
                6:    mm = 64'($urandom | 32'h8000_0000);
                7:    mm = (kind == 9) ? 64'(0) : 64'($urandom_range(1, 1000));
                default: mm = 64'($urandom);
            endcase
            if (kind < 7 && mm != 0) begin
                rr = x % mm;
                if ($urandom_range(0, 5) == 0 && rr + mm <= 64'hFFFF_FFFF) rr = rr + mm;
            end else begin
                rr = 64'($urandom);
            end
            send_word(rr[crt_pkg::IN_W-1:0], mm[crt_pkg::IN_W-1:0], k == len - 1);
        end
    endtask

    task automatic test_random_sets();
        while (n_words < 1050) random_set();
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_tail();
        idle_on = 1'b0;
        while (n_words < 1150) random_set();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_sets();
        test_special_moduli();
        test_failures();
        test_pressure();
        test_random_sets();
        test_steady_tail();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4000) @(posedge i_clk);
        $display("Sent %0d congruence words; checked %0d result words.", n_words, n_results);
        $display("Sets ending inconsistent: %0d, in overflow: %0d.", n_inconsistent,
                 n_overflow);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("crt_congruence_combiner test passed");
        end else begin
            $display("crt_congruence_combiner test failed");
        end
        $finish;
    end

endmodule
